// ===== hdl/coded_packet_credit_pacer_defines.svh =====
// Assertion macros shared by the credit pacer checker.
// Depends on nothing; the including scope provides aclk and aresetn.
`ifndef CODED_PACKET_CREDIT_PACER_DEFINES_SVH
`define CODED_PACKET_CREDIT_PACER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CPCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CPCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cpcp_pkg.sv =====
// Constants and codes of the coded packet credit pacer.
// Used by the top level and by its checker; depends on nothing.
package cpcp_pkg;

    localparam int CREDIT_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX = {CREDIT_W{1'b1}};
    localparam logic [CREDIT_W-1:0] PACKET_CREDIT = CREDIT_W'(100);

    localparam logic [1:0] KIND_SOURCE = 2'd0;
    localparam logic [1:0] KIND_CODED = 2'd1;
    localparam logic [1:0] KIND_FEEDBACK = 2'd2;
    localparam logic [1:0] KIND_FLUSH = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_CODED = 2'd1;
    localparam logic [1:0] ST_FUTURE_FB = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PACE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS = 2'd2;

    localparam logic [15:0] PACE_RESET = 16'd120;
    localparam logic [15:0] TAIL_RESET = 16'd100;
    localparam logic [15:0] SYMBOLS_RESET = 16'd16;
    localparam logic [31:0] GEN_RESET = 32'd1;

endpackage

// ===== hdl/coded_packet_credit_pacer.sv =====
// Top level of the coded packet credit pacer: input register, event logic,
// generation/credit state and result register. Depends on cpcp_pkg.
//
// Channel   Direction  Handshake            Contents
// s_        in         s_valid / s_ready    kind, fb_generation, fb_rank
// m_        out        m_valid / m_ready    status, header, ready/full/complete
// cfg_      in         cfg_we (no wait)     cfg_index, cfg_wdata
//
// One transaction is taken per clock cycle, sustained, as long as m_ready does
// not stall the result register. An accepted transaction first waits in the
// input register; the event logic then loads the result register, which is
// also where the generation, rank, credit and complete state is updated, and
// the result is offered on the m_ ports from there.
// aresetn is synchronous and active low; it empties both registers and
// restores the configuration and state to their reset values.
// A stall on m_ready holds the result. With the input register occupied,
// s_ready falls in the same cycle; with it empty, one further transaction is
// taken first.
module coded_packet_credit_pacer
    import cpcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [31:0]           s_fb_generation,
    input  logic [15:0]           s_fb_rank,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [31:0]           m_hdr_generation,
    output logic [15:0]           m_hdr_rank,
    output logic                  m_coded_ready,
    output logic                  m_gen_full,
    output logic                  m_gen_complete
);

    // Configuration registers.
    logic [15:0] pace_reg;
    logic [15:0] tail_reg;
    logic [15:0] sym_reg;

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic [31:0] in_fb_gen_reg;
    logic [15:0] in_fb_rank_reg;

    // Pacer state.
    logic [31:0]         gen_reg;
    logic [15:0]         rank_reg;
    logic [CREDIT_W-1:0] credit_reg;
    logic                complete_reg;

    // Result register.
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] hdr_gen_reg;
    logic [15:0] hdr_rank_reg;
    logic        coded_ready_reg;
    logic        gen_full_reg;
    logic        gen_complete_reg;

    // Next values of the state.
    logic [31:0]         gen_next;
    logic [15:0]         rank_next;
    logic [CREDIT_W-1:0] credit_next;
    logic                complete_next;
    logic [1:0]          status_next;

    logic                advance;
    logic                new_gen;
    logic [CREDIT_W-1:0] base_credit;
    logic [15:0]         rank_inc;
    logic [16:0]         add_amount;
    logic [CREDIT_W:0]   credit_sum;
    logic [CREDIT_W-1:0] credit_sat;
    logic                ready_next;

    // The item in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // A source packet arriving at a full generation opens the next one.
    assign new_gen = (in_kind_reg == KIND_SOURCE) && (rank_reg == sym_reg);
    assign base_credit = new_gen ? '0 : credit_reg;
    assign rank_inc = (new_gen ? 16'd0 : rank_reg) + 16'd1;

    // Pace and tail credit are summed first: saturating once on the total
    // gives the same value as saturating after each addition.
    always_comb begin
        case (in_kind_reg)
            KIND_SOURCE: begin
                add_amount = {1'b0, pace_reg} +
                             ((rank_inc == sym_reg) ? {1'b0, tail_reg} : 17'd0);
            end
            KIND_FLUSH: begin
                add_amount = {1'b0, tail_reg};
            end
            default: begin
                add_amount = 17'd0;
            end
        endcase
    end

    assign credit_sum = {1'b0, base_credit} + {{(CREDIT_W - 16){1'b0}}, add_amount};
    assign credit_sat = credit_sum[CREDIT_W] ? CREDIT_MAX : credit_sum[CREDIT_W-1:0];

    always_comb begin
        gen_next = gen_reg;
        rank_next = rank_reg;
        credit_next = credit_reg;
        complete_next = complete_reg;
        status_next = ST_OK;
        case (in_kind_reg)
            KIND_SOURCE: begin
                if (new_gen) begin
                    gen_next = gen_reg + 32'd1;
                    complete_next = 1'b0;
                end
                rank_next = rank_inc;
                credit_next = credit_sat;
            end
            KIND_CODED: begin
                if (credit_reg >= PACKET_CREDIT) begin
                    credit_next = credit_reg - PACKET_CREDIT;
                end else begin
                    status_next = ST_NO_CODED;
                end
            end
            KIND_FEEDBACK: begin
                // Feedback from an older generation is ignored.
                if (in_fb_gen_reg > gen_reg) begin
                    status_next = ST_FUTURE_FB;
                end else if (in_fb_gen_reg == gen_reg) begin
                    if (in_fb_rank_reg == rank_reg) begin
                        credit_next = '0;
                    end
                    if (in_fb_rank_reg == sym_reg) begin
                        complete_next = 1'b1;
                    end
                end
            end
            KIND_FLUSH: begin
                credit_next = credit_sat;
            end
            default: begin
                credit_next = credit_reg;
            end
        endcase
    end

    assign ready_next = credit_next >= PACKET_CREDIT;

    // Configuration writes to indexes beyond the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pace_reg <= PACE_RESET;
            tail_reg <= TAIL_RESET;
            sym_reg <= SYMBOLS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PACE: begin
                    pace_reg <= cfg_wdata;
                end
                CFG_TAIL: begin
                    tail_reg <= cfg_wdata;
                end
                CFG_SYMBOLS: begin
                    sym_reg <= cfg_wdata;
                end
                default: begin
                    pace_reg <= pace_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_fb_gen_reg <= s_fb_generation;
            in_fb_rank_reg <= s_fb_rank;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= GEN_RESET;
            rank_reg <= '0;
            credit_reg <= '0;
            complete_reg <= 1'b0;
        end else if (advance) begin
            gen_reg <= gen_next;
            rank_reg <= rank_next;
            credit_reg <= credit_next;
            complete_reg <= complete_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= status_next;
            hdr_gen_reg <= gen_next;
            hdr_rank_reg <= rank_next;
            coded_ready_reg <= ready_next;
            gen_full_reg <= ready_next && (rank_next == sym_reg);
            gen_complete_reg <= complete_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_status = status_reg;
    assign m_hdr_generation = hdr_gen_reg;
    assign m_hdr_rank = hdr_rank_reg;
    assign m_coded_ready = coded_ready_reg;
    assign m_gen_full = gen_full_reg;
    assign m_gen_complete = gen_complete_reg;

endmodule

// ===== hdl/cpcp_checker.sv =====
// Port-level assertions for the coded packet credit pacer, bound to the top.
// Depends on cpcp_pkg and coded_packet_credit_pacer_defines.svh.
`include "coded_packet_credit_pacer_defines.svh"

module cpcp_checker
    import cpcp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_status,
    input logic [31:0]           m_hdr_generation,
    input logic [15:0]           m_hdr_rank,
    input logic                  m_coded_ready,
    input logic                  m_gen_full
);

    // A stalled result stays offered and unchanged.
    `CPCP_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_hdr_generation) && $stable(m_hdr_rank), "result changed while stalled")

    // A full generation is only flagged when a coded packet can be sent.
    `CPCP_ASSERT_NOW(a_full_needs_ready, m_valid && m_gen_full, m_coded_ready, "gen_full without coded_ready")

    // A refused request leaves the credit below one packet.
    `CPCP_ASSERT_NOW(a_refused_not_ready, m_valid && (m_status == ST_NO_CODED), !m_coded_ready, "refused request but credit ready")

    // Input back-pressure only occurs behind a stalled, full result register.
    `CPCP_ASSERT_NOW(a_backpressure_cause, !s_ready, m_valid && !m_ready, "s_ready low without output stall")

endmodule

bind coded_packet_credit_pacer cpcp_checker u_cpcp_checker (.*);

// ===== sim/credit_pacer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the coded packet credit pacer: watches the configuration port and
// both channels, predicts every result and compares it field by field.
// Depends on cpcp_pkg for widths, event kinds, status codes and register indexes.
module credit_pacer_checker
    import cpcp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [31:0]           s_fb_generation,
    input  logic [15:0]           s_fb_rank,

    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [1:0]            m_status,
    input  logic [31:0]           m_hdr_generation,
    input  logic [15:0]           m_hdr_rank,
    input  logic                  m_coded_ready,
    input  logic                  m_gen_full,
    input  logic                  m_gen_complete,

    output int unsigned           error_count,
    output int unsigned           accepted_count,
    output int unsigned           checked_count,
    output logic [31:0]           gen_now,
    output logic [15:0]           rank_now
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] generation;
        logic [15:0] rank;
        logic        coded_ready;
        logic        gen_full;
        logic        gen_complete;
    } pacer_result_t;

    // Predicted pacer state and configuration.
    logic [31:0]         gen_q;
    logic [15:0]         rank_q;
    logic [CREDIT_W-1:0] credit_q;
    logic                complete_q;
    logic [15:0]         pace_cfg;
    logic [15:0]         tail_cfg;
    logic [15:0]         symbols_cfg;

    pacer_result_t expected_results[$];
    int unsigned   errors = 0;
    int unsigned   accepted = 0;
    int unsigned   checked = 0;

    // Credit additions clip at the top of the counter.
    function automatic logic [CREDIT_W-1:0] credit_plus(logic [CREDIT_W-1:0] base,
                                                        logic [15:0] amount);
        logic [CREDIT_W:0] sum;
        sum = {1'b0, base} + {{(CREDIT_W - 15){1'b0}}, amount};
        return sum[CREDIT_W] ? CREDIT_MAX : sum[CREDIT_W-1:0];
    endfunction

    function automatic pacer_result_t step_pacer(logic [1:0] kind, logic [31:0] fb_gen,
                                                 logic [15:0] fb_rank);
        pacer_result_t r;
        r.status = ST_OK;
        case (kind)
            KIND_SOURCE: begin
                // A full generation is only closed by the next source packet.
                if (rank_q == symbols_cfg) begin
                    gen_q = gen_q + 32'd1;
                    rank_q = '0;
                    credit_q = '0;
                    complete_q = 1'b0;
                end
                rank_q = rank_q + 16'd1;
                credit_q = credit_plus(credit_q, pace_cfg);
                if (rank_q == symbols_cfg)
                    credit_q = credit_plus(credit_q, tail_cfg);
            end
            KIND_CODED: begin
                if (credit_q >= PACKET_CREDIT)
                    credit_q = credit_q - PACKET_CREDIT;
                else
                    r.status = ST_NO_CODED;
            end
            KIND_FEEDBACK: begin
                if (fb_gen > gen_q) begin
                    r.status = ST_FUTURE_FB;
                end else if (fb_gen == gen_q) begin
                    if (fb_rank == rank_q)
                        credit_q = '0;
                    if (fb_rank == symbols_cfg)
                        complete_q = 1'b1;
                end
            end
            default: begin
                credit_q = credit_plus(credit_q, tail_cfg);
            end
        endcase
        r.generation = gen_q;
        r.rank = rank_q;
        r.coded_ready = credit_q >= PACKET_CREDIT;
        r.gen_full = r.coded_ready && (rank_q == symbols_cfg);
        r.gen_complete = complete_q;
        return r;
    endfunction

    function automatic int unsigned field_mismatch(string field, longint unsigned want,
                                                   longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        pacer_result_t want;
        if (!aresetn) begin
            gen_q = GEN_RESET;
            rank_q = '0;
            credit_q = '0;
            complete_q = 1'b0;
            pace_cfg = PACE_RESET;
            tail_cfg = TAIL_RESET;
            symbols_cfg = SYMBOLS_RESET;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                checked++;
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation waiting (generation %0d)",
                           m_hdr_generation);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    errors += field_mismatch("status", 64'(want.status), 64'(m_status));
                    errors += field_mismatch("hdr_generation", 64'(want.generation),
                                             64'(m_hdr_generation));
                    errors += field_mismatch("hdr_rank", 64'(want.rank), 64'(m_hdr_rank));
                    errors += field_mismatch("coded_ready", 64'(want.coded_ready),
                                             64'(m_coded_ready));
                    errors += field_mismatch("gen_full", 64'(want.gen_full),
                                             64'(m_gen_full));
                    errors += field_mismatch("gen_complete", 64'(want.gen_complete),
                                             64'(m_gen_complete));
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(step_pacer(s_kind, s_fb_generation, s_fb_rank));
                accepted++;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PACE:    pace_cfg = cfg_wdata;
                    CFG_TAIL:    tail_cfg = cfg_wdata;
                    CFG_SYMBOLS: symbols_cfg = cfg_wdata;
                    default: ;
                endcase
            end
        end
        error_count <= errors;
        accepted_count <= accepted;
        checked_count <= checked;
        gen_now <= gen_q;
        rank_now <= rank_q;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top of the credit pacer testbench: clock, reset, stimulus and verdict.
// Depends on cpcp_pkg, the coded_packet_credit_pacer block and credit_pacer_checker.
module tb;
    import cpcp_pkg::*;

    // The watchdog allows several times the slowest expected run, with idling
    // on both sides, the long receiver hold and the drains before each change
    // of settings.
    localparam int unsigned CYCLE_LIMIT = 40_000;

    // The receiver stops taking results for this many cycles once the sender
    // has had this many transactions accepted, so that the block backs up.
    localparam int unsigned HOLD_AT = 700;
    localparam int unsigned HOLD_CYCLES = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_kind = KIND_SOURCE;
    logic [31:0]           s_fb_generation = '0;
    logic [15:0]           s_fb_rank = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_status;
    logic [31:0]           m_hdr_generation;
    logic [15:0]           m_hdr_rank;
    logic                  m_coded_ready;
    logic                  m_gen_full;
    logic                  m_gen_complete;

    int unsigned           error_count;
    int unsigned           accepted_count;
    int unsigned           checked_count;
    logic [31:0]           gen_now;
    logic [15:0]           rank_now;

    // Stimulus bookkeeping, owned by the sender process.
    int unsigned           sent_count = 0;
    int unsigned           kind_count[4] = '{0, 0, 0, 0};
    int unsigned           setting_count = 0;
    logic [15:0]           symbols_now = SYMBOLS_RESET;

    always #1 aclk = ~aclk;

    coded_packet_credit_pacer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_fb_generation  (s_fb_generation),
        .s_fb_rank        (s_fb_rank),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_hdr_generation (m_hdr_generation),
        .m_hdr_rank       (m_hdr_rank),
        .m_coded_ready    (m_coded_ready),
        .m_gen_full       (m_gen_full),
        .m_gen_complete   (m_gen_complete)
    );

    // The checker sits beside the block, sees exactly what the block sees and
    // hands back its error count, its progress and the predicted generation and
    // rank, which the sender uses to aim feedback at the live generation.
    credit_pacer_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_fb_generation  (s_fb_generation),
        .s_fb_rank        (s_fb_rank),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_hdr_generation (m_hdr_generation),
        .m_hdr_rank       (m_hdr_rank),
        .m_coded_ready    (m_coded_ready),
        .m_gen_full       (m_gen_full),
        .m_gen_complete   (m_gen_complete),
        .error_count      (error_count),
        .accepted_count   (accepted_count),
        .checked_count    (checked_count),
        .gen_now          (gen_now),
        .rank_now         (rank_now)
    );

    // Offers one transaction and returns at the edge where it is accepted.
    // Idle cycles are inserted before the offer, never once valid is up, and
    // the valid line receives a single nonblocking assignment per time step.
    // Between transactions 300 and 600 the sender never idles.
    task automatic send_event(input logic [1:0] kind, input logic [31:0] fb_gen,
                              input logic [15:0] fb_rank);
        while (!(sent_count >= 300 && sent_count < 600) && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_fb_generation <= fb_gen;
        s_fb_rank <= fb_rank;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent_count++;
        kind_count[kind]++;
    endtask

    // Lowers valid and waits until every accepted transaction has produced its
    // result. Every event yields exactly one result, so once the counts agree
    // the block holds nothing in flight.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (accepted_count != checked_count)
            @(posedge aclk);
    endtask

    // Writes all three registers on consecutive edges; only called when idle.
    task automatic write_config(input logic [15:0] pace, input logic [15:0] tail,
                                input logic [15:0] symbols);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PACE;
        cfg_wdata <= pace;
        @(posedge aclk);
        cfg_index <= CFG_TAIL;
        cfg_wdata <= tail;
        @(posedge aclk);
        cfg_index <= CFG_SYMBOLS;
        cfg_wdata <= symbols;
        @(posedge aclk);
        cfg_we <= 1'b0;
        symbols_now = symbols;
        setting_count++;
    endtask

    // Random traffic. Feedback targets the live generation half the time and
    // mostly carries the live rank or the symbol count, so that credit clears
    // and completion are reached often; the remainder is stale, future or entirely random.
    // Fields that a kind ignores still carry random bits.
    task automatic random_traffic(input int unsigned count);
        int unsigned pick;
        logic [1:0]  kind;
        logic [31:0] fb_gen;
        logic [15:0] fb_rank;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                kind = KIND_SOURCE;
            else if (pick < 65)
                kind = KIND_CODED;
            else if (pick < 88)
                kind = KIND_FEEDBACK;
            else
                kind = KIND_FLUSH;
            fb_gen = $urandom;
            fb_rank = $urandom_range(0, 65535);
            if (kind == KIND_FEEDBACK) begin
                case ($urandom_range(0, 5))
                    0, 1, 2: fb_gen = gen_now;
                    3:       fb_gen = gen_now - 32'd1;
                    4:       fb_gen = gen_now + 32'd1;
                    default: ;
                endcase
                case ($urandom_range(0, 3))
                    0, 1:    fb_rank = rank_now;
                    2:       fb_rank = symbols_now;
                    default: ;
                endcase
            end
            send_event(kind, fb_gen, fb_rank);
        end
    endtask

    task automatic random_phase(input logic [15:0] pace, input logic [15:0] tail,
                                input logic [15:0] symbols, input int unsigned count);
        wait_idle();
        write_config(pace, tail, symbols);
        random_traffic(count);
    endtask

    // Receiver: idles at random 30 percent of the time, never idles while the
    // sender is between transactions 1000 and 1300, and holds off once for a
    // long stretch so that both internal registers fill and s_ready falls.
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (sent_count >= 1000 && sent_count < 1300) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // Watchdog: a missing result or a wedged handshake ends the run here.
    initial begin
        int unsigned cycle;
        for (cycle = 0; cycle < CYCLE_LIMIT; cycle++)
            @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening with the reset configuration: a refused request,
        // future feedback (including the largest generation number), stale
        // feedback, credit spending, a credit clear on a rank match, completion
        // on a symbol-count match and a flush.
        send_event(KIND_CODED, 32'd0, 16'd0);
        send_event(KIND_FEEDBACK, 32'd2, 16'd0);
        send_event(KIND_FEEDBACK, 32'd0, 16'd0);
        send_event(KIND_FEEDBACK, 32'hFFFF_FFFF, 16'hFFFF);
        send_event(KIND_SOURCE, 32'hFFFF_FFFF, 16'hFFFF);
        send_event(KIND_SOURCE, 32'd0, 16'd0);
        send_event(KIND_CODED, 32'd0, 16'd0);
        send_event(KIND_FEEDBACK, 32'd1, 16'd2);
        send_event(KIND_FEEDBACK, 32'd1, 16'd16);
        send_event(KIND_FLUSH, 32'd0, 16'd0);
        send_event(KIND_CODED, 32'd0, 16'd0);
        send_event(KIND_CODED, 32'd0, 16'd0);

        // Symbol count dropped below the current rank: the rank keeps counting.
        wait_idle();
        write_config(PACE_RESET, TAIL_RESET, 16'd1);
        send_event(KIND_SOURCE, 32'd0, 16'd0);
        send_event(KIND_SOURCE, 32'd0, 16'd0);

        // Raised again so the next source packet fills the generation, then
        // feedback completes it, a further source opens generation two and
        // feedback for generation one becomes stale.
        wait_idle();
        write_config(PACE_RESET, TAIL_RESET, 16'd5);
        send_event(KIND_SOURCE, 32'd0, 16'd0);
        send_event(KIND_FEEDBACK, 32'd1, 16'd5);
        send_event(KIND_SOURCE, 32'd0, 16'd0);
        send_event(KIND_FEEDBACK, 32'd1, 16'd0);

        // Random phases across extreme and mid-range settings. Small symbol
        // counts keep generations turning over; the largest never fills, and
        // a symbol count of zero lets the rank run on.
        random_phase(16'd0, 16'hFFFF, 16'd1, 250);
        random_phase(16'hFFFF, 16'd0, 16'd3, 250);
        random_phase(16'd30, 16'd45, 16'hFFFF, 200);
        random_phase(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                     16'($urandom_range(2, 8)), 300);
        random_phase(16'd100, 16'd100, 16'd0, 150);
        random_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(1, 5)), 400);

        // Largest credit steps. Setting the symbol count to the live rank
        // makes the next source packet open a fresh generation with rank one.
        // With a symbol count of zero the rank then runs on while the largest
        // pace and tail credit pile up, and requests, feedback and flushes act
        // on a large balance.
        wait_idle();
        write_config(16'hFFFF, 16'hFFFF, rank_now);
        send_event(KIND_SOURCE, $urandom, 16'($urandom));
        wait_idle();
        write_config(16'hFFFF, 16'hFFFF, 16'd0);
        repeat (8)
            send_event(KIND_SOURCE, $urandom, 16'($urandom));
        repeat (3)
            send_event(KIND_FLUSH, $urandom, 16'($urandom));
        repeat (2)
            send_event(KIND_CODED, $urandom, 16'($urandom));
        send_event(KIND_FLUSH, $urandom, 16'($urandom));
        send_event(KIND_FEEDBACK, gen_now, rank_now);
        send_event(KIND_CODED, $urandom, 16'($urandom));

        // Drain, then keep clocking so that any spurious extra result is caught
        // by the checker.
        wait_idle();
        repeat (8) @(posedge aclk);

        $display("Run covered %0d transactions: %0d source, %0d request, %0d feedback, %0d flush.",
                 sent_count, kind_count[KIND_SOURCE], kind_count[KIND_CODED],
                 kind_count[KIND_FEEDBACK], kind_count[KIND_FLUSH]);
        $display("%0d results compared over %0d register settings, up to the largest credit steps.",
                 checked_count, setting_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
